// ===== src/differential_drive_supervisor_core_defines.svh =====
// Assertion macros for the differential drive supervisor core.
// Uses clk and rst_n of the including module; empty when SYNTH is set.
`ifndef DIFFERENTIAL_DRIVE_SUPERVISOR_CORE_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_SUPERVISOR_CORE_DEFINES_SVH

`ifndef SYNTH

`define DDS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define DDS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define DDS_ASSERT_IMP(label, ante, cons)

`define DDS_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== src/dds_pkg.sv =====
// Shared constants, codes and helpers for the differential drive supervisor.
// No dependencies.
package dds_pkg;

    // Field widths
    localparam int REQ_W   = 2;
    localparam int CMD_W   = 16;
    localparam int DIST_W  = 10;
    localparam int CLEAR_W = 12;
    localparam int FS_W    = 16;
    localparam int REF_W   = 8;
    localparam int MAG_W   = 8;
    localparam int DRIVE_W = 18;
    localparam int MODE_W  = 2;
    localparam int PROD_W  = FS_W + MAG_W;

    // Stream and configuration port widths
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 8;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Default blink period in ticks
    localparam int BLINK_PERIOD_DEF = 500;

    // Register reset values
    localparam logic [DIST_W-1:0]  THRESH_RST = 10'd20;
    localparam logic [CLEAR_W-1:0] CLEAR_RST  = 12'd2500;
    localparam logic [FS_W-1:0]    FS_RST     = 16'd10000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FS     = 2'd2;

    // Command codes
    localparam logic [REQ_W-1:0] REQ_NONE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_START = 2'd3;

    // Mode codes as seen on the output
    localparam logic [MODE_W-1:0] MODE_WAIT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MOVING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EMERG  = 2'd2;

    // Reference limit
    localparam logic signed [REF_W-1:0] REF_LIMIT = 8'sd100;

    // floor(x / 100) = (x * DIV100_MULT) >> DIV100_SHIFT, exact for x < 2^24
    localparam int                RECIP_W      = 25;
    localparam int                DIV100_SHIFT = 31;
    localparam logic [RECIP_W-1:0] DIV100_MULT = 25'd21474837;

    // Result status fields, mode_now in the lowest bits
    typedef struct packed {
        logic              lights_on;
        logic              emergency_cleared;
        logic              emergency_entered;
        logic [MODE_W-1:0] mode_now;
    } status_t;

    function automatic logic signed [REF_W-1:0] clamp_ref(input logic signed [CMD_W-1:0] v);
        logic signed [REF_W-1:0] r;
        if (v > CMD_W'(REF_LIMIT))
        begin
            r = REF_LIMIT;
        end
        else if (v < -CMD_W'(REF_LIMIT))
        begin
            r = -REF_LIMIT;
        end
        else
        begin
            r = v[REF_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== src/differential_drive_supervisor_core.sv =====
// Differential drive supervisor: mode machine, reference store and wheel drive mix.
// Depends on dds_pkg and differential_drive_supervisor_core_defines.svh.
//
// One control tick is taken per clock cycle while the output is not stalled; its result
// passes four registers: input register, mode/reference update with mix, full-scale
// multiply, then the divide by 100 done as a reciprocal multiply into the output
// register. The two multiplier stages follow the per-tick state update, which completes
// in the update stage, so transfers can follow back to back. Each stage holds while the
// one after it is full and stalled, so bubbles are absorbed. Configuration writes take
// effect at once and are meant for idle periods only.
`include "differential_drive_supervisor_core_defines.svh"

module differential_drive_supervisor_core #(
    parameter int BLINK_PERIOD = dds_pkg::BLINK_PERIOD_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [dds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dds_pkg::CFG_DAT_W-1:0]  cfg_wdata,
    // tick stream in
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // speed_cmd [15:0], yaw_cmd [31:16], obstacle_distance [41:32], zeros above
    input  logic [dds_pkg::S_TDATA_W-1:0]  s_tdata,
    // req_type [1:0], button_press [2], zeros above
    input  logic [dds_pkg::S_TUSER_W-1:0]  s_tuser,
    // result stream out
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // left_drive [17:0], right_drive [35:18], zeros above
    output logic [dds_pkg::M_TDATA_W-1:0]  m_tdata,
    // mode_now [1:0], emergency_entered [2], emergency_cleared [3], lights_on [4]
    output logic [dds_pkg::M_TUSER_W-1:0]  m_tuser
);
    import dds_pkg::*;

    localparam int PHASE_W = (BLINK_PERIOD > 2) ? $clog2(BLINK_PERIOD) : 1;
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(BLINK_PERIOD - 1);
    localparam int QPROD_W = PROD_W + RECIP_W;

    typedef enum logic [MODE_W-1:0] {
        ST_WAIT   = MODE_WAIT,
        ST_MOVING = MODE_MOVING,
        ST_EMERG  = MODE_EMERG
    } mode_t;

    // configuration
    logic [DIST_W-1:0]  thresh_reg;
    logic [CLEAR_W-1:0] clear_ticks_reg;
    logic [FS_W-1:0]    fs_reg;

    // supervisor state
    mode_t                   mode_reg, mode_next;
    logic signed [REF_W-1:0] speed_ref_reg, speed_ref_next;
    logic signed [REF_W-1:0] yaw_ref_reg, yaw_ref_next;
    logic [CLEAR_W-1:0]      clear_run_reg, clear_run_next;
    logic [PHASE_W-1:0]      phase_reg, phase_next;
    logic                    light_reg, light_next;

    // pipeline valids
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    logic adv1;

    // stage 1: input register
    logic [REQ_W-1:0]        req1_reg;
    logic signed [CMD_W-1:0] scmd1_reg;
    logic signed [CMD_W-1:0] ycmd1_reg;
    logic                    press1_reg;
    logic [DIST_W-1:0]       dist1_reg;

    // stage 2: mix magnitudes
    logic [MAG_W-1:0] lmag2_reg, rmag2_reg, lmag_next, rmag_next;
    logic             lneg2_reg, rneg2_reg, lneg_next, rneg_next;
    status_t          st2_reg, st_next;

    // stage 3: scaled products
    logic [PROD_W-1:0] lprod3_reg, rprod3_reg;
    logic              lneg3_reg, rneg3_reg;
    status_t           st3_reg;

    // stage 4: output register
    logic [DRIVE_W-1:0] left4_reg, right4_reg, left_next, right_next;
    status_t            st4_reg;

    // update logic temporaries
    mode_t                   mode_a, mode_b;
    logic                    entered_c, cleared_c;
    logic [CLEAR_W-1:0]      run_inc;
    logic signed [REF_W:0]   lmix, rmix;
    logic [REF_W:0]          lmix_n, rmix_n;
    logic [QPROD_W-1:0]      lq_full, rq_full;
    logic [DRIVE_W-1:0]      lq, rq;

    // handshake: a stage takes a new item when empty or when it moves on
    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign adv1     = v1_reg && rdy2;

    // ---------------- per-tick supervisor update ----------------
    always_comb
    begin
        mode_a         = mode_reg;
        speed_ref_next = speed_ref_reg;
        yaw_ref_next   = yaw_ref_reg;
        clear_run_next = clear_run_reg;
        light_next     = light_reg;
        entered_c      = 1'b0;
        cleared_c      = 1'b0;
        run_inc        = (&clear_run_reg) ? clear_run_reg : clear_run_reg + 1'b1;

        // button toggles wait/moving outside emergency
        if (press1_reg && mode_reg != ST_EMERG)
        begin
            mode_a = (mode_reg == ST_WAIT) ? ST_MOVING : ST_WAIT;
        end

        mode_b = mode_a;
        case (req1_reg)
            REQ_SET:
            begin
                speed_ref_next = clamp_ref(scmd1_reg);
                yaw_ref_next   = clamp_ref(ycmd1_reg);
            end
            REQ_STOP:
            begin
                if (mode_a != ST_EMERG)
                begin
                    mode_b = ST_WAIT;
                end
            end
            REQ_START:
            begin
                if (mode_a != ST_EMERG)
                begin
                    mode_b = ST_MOVING;
                end
            end
            default:
            begin
                mode_b = mode_a;
            end
        endcase

        mode_next = mode_b;
        case (mode_b)
            ST_MOVING:
            begin
                if (dist1_reg < thresh_reg)
                begin
                    mode_next      = ST_EMERG;
                    entered_c      = 1'b1;
                    clear_run_next = '0;
                end
            end
            ST_EMERG:
            begin
                if (phase_reg == '0)
                begin
                    light_next = !light_reg;
                end
                clear_run_next = (dist1_reg >= thresh_reg) ? run_inc : '0;
                if (clear_run_next >= clear_ticks_reg)
                begin
                    mode_next  = ST_WAIT;
                    cleared_c  = 1'b1;
                    light_next = 1'b0;
                end
            end
            default:
            begin
                mode_next = ST_WAIT;
            end
        endcase

        phase_next = (phase_reg == PHASE_LAST) ? '0 : phase_reg + 1'b1;

        // wheel mix from the updated references, zero unless moving
        lmix   = {speed_ref_next[REF_W-1], speed_ref_next}
               - {yaw_ref_next[REF_W-1], yaw_ref_next};
        rmix   = {speed_ref_next[REF_W-1], speed_ref_next}
               + {yaw_ref_next[REF_W-1], yaw_ref_next};
        lmix_n = -lmix;
        rmix_n = -rmix;
        lneg_next = lmix[REF_W];
        rneg_next = rmix[REF_W];
        lmag_next = lmix[REF_W] ? lmix_n[MAG_W-1:0] : lmix[MAG_W-1:0];
        rmag_next = rmix[REF_W] ? rmix_n[MAG_W-1:0] : rmix[MAG_W-1:0];
        if (mode_next != ST_MOVING)
        begin
            lmag_next = '0;
            rmag_next = '0;
        end

        st_next.mode_now          = mode_next;
        st_next.emergency_entered = entered_c;
        st_next.emergency_cleared = cleared_c;
        st_next.lights_on         = light_next;
    end

    // state, configuration and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg      <= THRESH_RST;
            clear_ticks_reg <= CLEAR_RST;
            fs_reg          <= FS_RST;
            mode_reg        <= ST_WAIT;
            speed_ref_reg   <= '0;
            yaw_ref_reg     <= '0;
            clear_run_reg   <= '0;
            phase_reg       <= '0;
            light_reg       <= 1'b0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            v4_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_THRESH: thresh_reg      <= cfg_wdata[DIST_W-1:0];
                    CFG_CLEAR:  clear_ticks_reg <= cfg_wdata[CLEAR_W-1:0];
                    CFG_FS:     fs_reg          <= cfg_wdata[FS_W-1:0];
                    default:    thresh_reg      <= thresh_reg;
                endcase
            end
            if (adv1)
            begin
                mode_reg      <= mode_next;
                speed_ref_reg <= speed_ref_next;
                yaw_ref_reg   <= yaw_ref_next;
                clear_run_reg <= clear_run_next;
                phase_reg     <= phase_next;
                light_reg     <= light_next;
            end
            if (rdy1)
            begin
                v1_reg <= s_tvalid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // ---------------- datapath ----------------
    always_comb
    begin
        lq_full    = QPROD_W'(lprod3_reg) * QPROD_W'(DIV100_MULT);
        rq_full    = QPROD_W'(rprod3_reg) * QPROD_W'(DIV100_MULT);
        lq         = lq_full[DIV100_SHIFT +: DRIVE_W];
        rq         = rq_full[DIV100_SHIFT +: DRIVE_W];
        left_next  = lneg3_reg ? -lq : lq;
        right_next = rneg3_reg ? -rq : rq;
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && s_tvalid)
        begin
            req1_reg   <= s_tuser[REQ_W-1:0];
            press1_reg <= s_tuser[REQ_W];
            scmd1_reg  <= s_tdata[CMD_W-1:0];
            ycmd1_reg  <= s_tdata[2*CMD_W-1:CMD_W];
            dist1_reg  <= s_tdata[2*CMD_W +: DIST_W];
        end
        if (adv1)
        begin
            lmag2_reg <= lmag_next;
            rmag2_reg <= rmag_next;
            lneg2_reg <= lneg_next;
            rneg2_reg <= rneg_next;
            st2_reg   <= st_next;
        end
        if (rdy3 && v2_reg)
        begin
            lprod3_reg <= PROD_W'(fs_reg) * PROD_W'(lmag2_reg);
            rprod3_reg <= PROD_W'(fs_reg) * PROD_W'(rmag2_reg);
            lneg3_reg  <= lneg2_reg;
            rneg3_reg  <= rneg2_reg;
            st3_reg    <= st2_reg;
        end
        if (rdy4 && v3_reg)
        begin
            left4_reg  <= left_next;
            right4_reg <= right_next;
            st4_reg    <= st3_reg;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {(M_TDATA_W - 2*DRIVE_W)'(0), right4_reg, left4_reg};
    assign m_tuser  = {(M_TUSER_W - $bits(status_t))'(0), st4_reg};

    // ---------------- assertions ----------------
    `DDS_ASSERT_IMP(a_drive_zero_unless_moving,
        m_tvalid && st4_reg.mode_now != MODE_MOVING,
        left4_reg == '0 && right4_reg == '0)
    `DDS_ASSERT_IMP(a_entered_means_emerg,
        m_tvalid && st4_reg.emergency_entered,
        st4_reg.mode_now == MODE_EMERG && !st4_reg.emergency_cleared)
    `DDS_ASSERT_IMP(a_cleared_means_wait_dark,
        m_tvalid && st4_reg.emergency_cleared,
        st4_reg.mode_now == MODE_WAIT && !st4_reg.lights_on)
    `DDS_ASSERT_IMP(a_leave_emerg_needs_run,
        adv1 && mode_reg == ST_EMERG && mode_next != ST_EMERG,
        clear_run_next >= clear_ticks_reg && cleared_c)
    `DDS_ASSERT_NXT(a_entry_lands_in_emerg,
        adv1 && entered_c,
        mode_reg == ST_EMERG && clear_run_reg == '0)

endmodule

// ===== dv/differential_drive_supervisor_core_tb.sv =====
// Self-checking testbench for differential_drive_supervisor_core: directed ticks, then
// randomized phases over several register settings, each result checked against a predictor.
// Depends on dds_pkg and the core RTL only.
module differential_drive_supervisor_core_tb;
    import dds_pkg::*;

    localparam int BLINK       = 500;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]         req;
        logic signed [CMD_W-1:0]  speed;
        logic signed [CMD_W-1:0]  yaw;
        logic                     press;
        logic [DIST_W-1:0]        distance;
    } tick_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] left;
        logic signed [DRIVE_W-1:0] right;
        status_t                   status;
    } drive_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DAT_W-1:0]  cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    // predictor copy of the registers and state
    logic [DIST_W-1:0]  thresh_reg;
    logic [CLEAR_W-1:0] clear_reg;
    logic [FS_W-1:0]    scale_reg;
    logic [MODE_W-1:0]  mode_st;
    int                 speed_st;
    int                 yaw_st;
    int                 clear_run_st;
    int                 phase_st;
    logic               lights_st;

    drive_result_t pending_results[$];
    bit            idle_on;
    int            errors;
    int            ticks_sent;
    int            results_checked;
    int            emerg_entries;
    int            emerg_clears;
    int            light_toggles;
    int            cycles;

    differential_drive_supervisor_core #(.BLINK_PERIOD(BLINK)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d results outstanding",
                         cycles, pending_results.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // receiver stalls in random bursts while idling is enabled
    initial
    begin
        int stall;
        stall = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!idle_on)
            begin
                m_tready <= 1'b1;
            end
            else if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 12) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic report_mismatch(input string field, input int got, input int want);
        errors++;
        if (errors <= 40)
        begin
            $display("mismatch on %s at result %0d: got %0d, expected %0d",
                     field, results_checked, got, want);
        end
    endtask

    // compare each result transfer with the oldest expectation
    initial
    begin
        drive_result_t want;
        status_t       got_st;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("result with nothing pending", 1, 0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    got_st = status_t'(m_tuser[4:0]);
                    if ($signed(m_tdata[17:0]) != want.left)
                        report_mismatch("left_drive", int'($signed(m_tdata[17:0])),
                                        int'(want.left));
                    if ($signed(m_tdata[35:18]) != want.right)
                        report_mismatch("right_drive", int'($signed(m_tdata[35:18])),
                                        int'(want.right));
                    if (got_st.mode_now != want.status.mode_now)
                        report_mismatch("mode_now", int'(got_st.mode_now),
                                        int'(want.status.mode_now));
                    if (got_st.emergency_entered != want.status.emergency_entered)
                        report_mismatch("emergency_entered", int'(got_st.emergency_entered),
                                        int'(want.status.emergency_entered));
                    if (got_st.emergency_cleared != want.status.emergency_cleared)
                        report_mismatch("emergency_cleared", int'(got_st.emergency_cleared),
                                        int'(want.status.emergency_cleared));
                    if (got_st.lights_on != want.status.lights_on)
                        report_mismatch("lights_on", int'(got_st.lights_on),
                                        int'(want.status.lights_on));
                    results_checked++;
                end
            end
        end
    end

    function automatic int limit_ref(input logic signed [CMD_W-1:0] v);
        int x;
        x = int'(v);
        if (x > 100)
            x = 100;
        else if (x < -100)
            x = -100;
        return x;
    endfunction

    function automatic logic signed [DRIVE_W-1:0] wheel_drive(input int mix);
        int mag;
        int scaled;
        mag = (mix < 0) ? -mix : mix;
        scaled = (int'(scale_reg) * mag) / 100;
        return (mix < 0) ? DRIVE_W'(-scaled) : DRIVE_W'(scaled);
    endfunction

    // order within a tick: button, then command, then mode step
    task automatic supervise_tick(input tick_t t, output drive_result_t r);
        r = '0;
        if (t.press && mode_st != MODE_EMERG)
            mode_st = (mode_st == MODE_WAIT) ? MODE_MOVING : MODE_WAIT;
        case (t.req)
            REQ_SET:
            begin
                speed_st = limit_ref(t.speed);
                yaw_st = limit_ref(t.yaw);
            end
            REQ_STOP:
            begin
                if (mode_st != MODE_EMERG)
                    mode_st = MODE_WAIT;
            end
            REQ_START:
            begin
                if (mode_st != MODE_EMERG)
                    mode_st = MODE_MOVING;
            end
            default:
            begin
            end
        endcase
        if (mode_st == MODE_MOVING)
        begin
            if (t.distance < thresh_reg)
            begin
                mode_st = MODE_EMERG;
                r.status.emergency_entered = 1'b1;
                clear_run_st = 0;
                emerg_entries++;
            end
            else
            begin
                r.left = wheel_drive(speed_st - yaw_st);
                r.right = wheel_drive(speed_st + yaw_st);
            end
        end
        else if (mode_st == MODE_EMERG)
        begin
            if (phase_st == 0)
            begin
                lights_st = ~lights_st;
                light_toggles++;
            end
            if (t.distance >= thresh_reg)
            begin
                if (clear_run_st < 4095)
                    clear_run_st++;
            end
            else
            begin
                clear_run_st = 0;
            end
            if (clear_run_st >= int'(clear_reg))
            begin
                mode_st = MODE_WAIT;
                r.status.emergency_cleared = 1'b1;
                lights_st = 1'b0;
                emerg_clears++;
            end
        end
        phase_st = (phase_st + 1 >= BLINK) ? 0 : phase_st + 1;
        r.status.mode_now = mode_st;
        r.status.lights_on = lights_st;
    endtask

    task automatic send_tick(input tick_t t);
        drive_result_t r;
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, t.distance, t.yaw, t.speed};
        s_tuser <= {5'b0, t.press, t.req};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        supervise_tick(t, r);
        pending_results.push_back(r);
        ticks_sent++;
    endtask

    // hold off until every expected result has come out
    task automatic drain;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DAT_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (index)
            CFG_THRESH: thresh_reg = value[DIST_W-1:0];
            CFG_CLEAR:  clear_reg = value[CLEAR_W-1:0];
            CFG_FS:     scale_reg = value;
            default:
            begin
            end
        endcase
    endtask

    function automatic tick_t tick_of(input logic [REQ_W-1:0] req, input int speed, input int yaw,
                                      input bit press, input int distance);
        tick_t t;
        t.req = req;
        t.speed = CMD_W'(speed);
        t.yaw = CMD_W'(yaw);
        t.press = press;
        t.distance = DIST_W'(distance);
        return t;
    endfunction

    function automatic logic signed [CMD_W-1:0] random_cmd;
        int picks[6];
        picks = '{-32768, 32767, -101, 101, -100, 100};
        case ($urandom_range(0, 3))
            0, 1:    return CMD_W'(int'($urandom_range(0, 240)) - 120);
            2:       return CMD_W'($urandom);
            default: return CMD_W'(picks[$urandom_range(0, 5)]);
        endcase
    endfunction

    // mostly well-formed: start often from wait, obstacles at set odds per mode
    function automatic tick_t random_tick(input int em_odds, input int mv_odds);
        tick_t t;
        int r;
        bit obstacle;
        r = $urandom_range(0, 99);
        t.req = (r < 50) ? REQ_NONE : (r < 72) ? REQ_SET : (r < 84) ? REQ_STOP : REQ_START;
        t.press = ($urandom_range(0, 9) == 0);
        t.speed = random_cmd();
        t.yaw = random_cmd();
        case (mode_st)
            MODE_EMERG:  obstacle = (em_odds != 0) && ($urandom_range(1, em_odds) == 1);
            MODE_MOVING: obstacle = ($urandom_range(1, mv_odds) == 1);
            default:     obstacle = $urandom_range(0, 1);
        endcase
        if (mode_st != MODE_EMERG && $urandom_range(0, 19) == 0)
            t.distance = DIST_W'($urandom);
        else if (obstacle && thresh_reg != 0)
            t.distance = DIST_W'($urandom_range(0, int'(thresh_reg) - 1));
        else
            t.distance = DIST_W'($urandom_range(int'(thresh_reg), 1023));
        return t;
    endfunction

    task automatic run_phase(input int thresh, input int clear, input int scale, input int count,
                             input int em_odds, input int mv_odds, input bit idle);
        drain();
        // upper write bits beyond each register width must be dropped
        write_reg(CFG_THRESH, {6'($urandom), 10'(thresh)});
        write_reg(CFG_CLEAR, {4'($urandom), 12'(clear)});
        write_reg(CFG_FS, 16'(scale));
        idle_on = idle;
        for (int i = 0; i < count; i++)
        begin
            if (idle && $urandom_range(0, 99) == 0)
                drain();
            send_tick(random_tick(em_odds, mv_odds));
        end
    endtask

    task automatic test_directed_cases;
        idle_on = 1'b1;
        send_tick(tick_of(REQ_NONE, 32767, -32768, 1'b0, 0));
        send_tick(tick_of(REQ_SET, 32767, -32768, 1'b0, 1023));
        send_tick(tick_of(REQ_START, 0, 0, 1'b0, 1023));
        send_tick(tick_of(REQ_SET, -101, 101, 1'b0, 20));
        send_tick(tick_of(REQ_SET, 100, 100, 1'b0, 512));
        send_tick(tick_of(REQ_SET, -100, -100, 1'b0, 700));
        send_tick(tick_of(REQ_SET, 37, -55, 1'b0, 341));
        send_tick(tick_of(REQ_NONE, 0, 0, 1'b1, 682));
        send_tick(tick_of(REQ_START, 0, 0, 1'b1, 100));
        send_tick(tick_of(REQ_STOP, 0, 0, 1'b1, 100));
        send_tick(tick_of(REQ_NONE, 0, 0, 1'b1, 100));
        send_tick(tick_of(REQ_STOP, 0, 0, 1'b0, 100));
        // enter emergency on the start tick itself, drives stay zero
        send_tick(tick_of(REQ_START, 0, 0, 1'b0, 19));
        send_tick(tick_of(REQ_NONE, 0, 0, 1'b1, 500));
        send_tick(tick_of(REQ_STOP, 0, 0, 1'b0, 500));
        send_tick(tick_of(REQ_START, 0, 0, 1'b0, 500));
        send_tick(tick_of(REQ_NONE, 0, 0, 1'b0, 3));
        send_tick(tick_of(REQ_SET, 50, -7, 1'b0, 600));
        // zero clear ticks: leave emergency even on an obstacle tick
        drain();
        write_reg(CFG_CLEAR, 16'd0);
        write_reg(CFG_UNUSED, 16'($urandom));
        send_tick(tick_of(REQ_NONE, 0, 0, 1'b0, 0));
        send_tick(tick_of(REQ_START, 0, 0, 1'b0, 1023));
        drain();
        write_reg(CFG_FS, 16'hFFFF);
        write_reg(CFG_THRESH, 16'd1023);
        send_tick(tick_of(REQ_SET, -100, 100, 1'b0, 1023));
        send_tick(tick_of(REQ_SET, 100, 100, 1'b0, 1023));
        send_tick(tick_of(REQ_NONE, 0, 0, 1'b0, 1022));
        send_tick(tick_of(REQ_NONE, 0, 0, 1'b0, 1023));
    endtask

    task automatic test_scale_extremes;
        run_phase(200, 0, 65535, 90, 6, 10, 1'b1);
        run_phase(50, 3, 0, 50, 6, 10, 1'b1);
    endtask

    task automatic test_threshold_extremes;
        run_phase(1023, 1, 12345, 70, 4, 3, 1'b1);
        run_phase(0, 5, 777, 50, 4, 8, 1'b1);
    endtask

    // emergency outlasts a full blink period, so the lights must toggle
    task automatic test_light_blink;
        run_phase(300, 510, 50000, 720, 0, 12, 1'b1);
    endtask

    // emergency held with the longest clear run, which the phase's ticks cannot reach
    task automatic test_held_emergency;
        run_phase(100, 4095, int'($urandom_range(0, 65535)), 60, 30, 4, 1'b1);
    endtask

    task automatic test_random_mix;
        run_phase(int'($urandom_range(0, 1023)), int'($urandom_range(1, 20)),
                  int'($urandom_range(0, 65535)), 100, 10, 10, 1'b0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        idle_on = 1'b0;
        errors = 0;
        ticks_sent = 0;
        results_checked = 0;
        emerg_entries = 0;
        emerg_clears = 0;
        light_toggles = 0;
        thresh_reg = THRESH_RST;
        clear_reg = CLEAR_RST;
        scale_reg = FS_RST;
        mode_st = MODE_WAIT;
        speed_st = 0;
        yaw_st = 0;
        clear_run_st = 0;
        phase_st = 0;
        lights_st = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_scale_extremes();
        test_threshold_extremes();
        test_light_blink();
        test_held_emergency();
        test_random_mix();
        drain();

        $display("%0d ticks over directed cases and seven random register settings, %0d checked",
                 ticks_sent, results_checked);
        $display("%0d emergencies entered, %0d cleared, %0d light toggles",
                 emerg_entries, emerg_clears, light_toggles);
        if (errors == 0 && pending_results.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
